// File: hdl/frame_sharpness_exposure_gate_assert.svh
// ----------------------------------------------------------------------------
// Frame sharpness / exposure gate - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef FRAME_SHARPNESS_EXPOSURE_GATE_ASSERT_SVH
`define FRAME_SHARPNESS_EXPOSURE_GATE_ASSERT_SVH

// same-cycle implication
`define FSEG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSEG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fse_pkg.sv
// ----------------------------------------------------------------------------
// fse_pkg
// Shared types and constants of the frame sharpness / exposure gate.
// ----------------------------------------------------------------------------
`default_nettype none

package fse_pkg;

  localparam int PIX_W      = 8;
  localparam int BLUR_W     = 28;
  localparam int BRIGHT_W   = 16;
  localparam int CONTRAST_W = 15;
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLUR_SCORE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BRIGHTNESS = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHTNESS = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONTRAST   = CFG_IDX_W'(6);

  // register reset values
  localparam logic                  RST_COLOR_MODE     = 1'b1;
  localparam logic [CFG_DIM_W-1:0]  RST_FRAME_WIDTH    = CFG_DIM_W'(640);
  localparam logic [CFG_DIM_W-1:0]  RST_FRAME_HEIGHT   = CFG_DIM_W'(480);
  localparam logic [BLUR_W-1:0]     RST_MIN_BLUR_SCORE = '0;
  localparam logic [BRIGHT_W-1:0]   RST_MIN_BRIGHTNESS = '0;
  localparam logic [BRIGHT_W-1:0]   RST_MAX_BRIGHTNESS = BRIGHT_W'(65280);
  localparam logic [CONTRAST_W-1:0] RST_MIN_CONTRAST   = '0;

  // BGR to gray, Q14
  localparam int GRAY_MIX_W   = 22;
  localparam int GRAY_B_COEF  = 1868;
  localparam int GRAY_G_COEF  = 9617;
  localparam int GRAY_R_COEF  = 4899;
  localparam int GRAY_ROUND   = 8192;
  localparam int GRAY_SHIFT   = 14;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

endpackage

`default_nettype wire

// File: hdl/fse_if.sv
// ----------------------------------------------------------------------------
// fse_pix_if / fse_res_if
// Valid/ready channels for pixel requests and frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fse_pix_if;
  import fse_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue_or_gray;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, output blue_or_gray, output green, output red,
                  input ready);
  modport sink   (input valid, input blue_or_gray, input green, input red,
                  output ready);
endinterface

interface fse_res_if;
  import fse_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [BLUR_W-1:0]     blur_score;
  logic [BRIGHT_W-1:0]   brightness;
  logic [CONTRAST_W-1:0] contrast;
  logic                  too_blurry;
  logic                  too_dark;
  logic                  too_bright;
  logic                  low_contrast;
  logic                  usable;

  modport source (output valid, output blur_score, output brightness,
                  output contrast, output too_blurry, output too_dark,
                  output too_bright, output low_contrast, output usable,
                  input ready);
  modport sink   (input valid, input blur_score, input brightness,
                  input contrast, input too_blurry, input too_dark,
                  input too_bright, input low_contrast, input usable,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/fse_ram.sv
// ----------------------------------------------------------------------------
// fse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/fse_alu.sv
// ----------------------------------------------------------------------------
// fse_alu
// Bit-serial multiply, restoring divide and integer square root on one adder.
// ----------------------------------------------------------------------------
`default_nettype none

module fse_alu #(
  parameter int W = 82
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fse_pkg::alu_req_t req_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output fse_pkg::alu_rsp_t rsp_o,
  output logic [W-1:0]      res_o
);
  import fse_pkg::*;

  localparam int CNT_W = $clog2(W + 1);
  localparam logic [W-1:0] SQRT_BIT = {2'b01, {(W-2){1'b0}}};

  logic             busy_q, done_q;
  alu_op_e          op_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     x_q, y_q, acc_q;
  logic [W-1:0]     x_n, y_n, acc_n;

  logic [W:0]       rem_t;
  logic [W+1:0]     add_a, add_b, sum;
  logic             sub, ge;

  // shared adder / subtractor
  always_comb begin
    rem_t = {acc_q, x_q[W-1]};
    add_a = '0;
    add_b = '0;
    sub   = 1'b0;
    case (op_q)
      ALU_MUL: begin
        add_a = (W+2)'(acc_q);
        add_b = (W+2)'(x_q);
      end
      ALU_DIV: begin
        add_a = (W+2)'(rem_t);
        add_b = (W+2)'(y_q);
        sub   = 1'b1;
      end
      ALU_SQRT: begin
        add_a = (W+2)'(x_q);
        add_b = (W+2)'(acc_q | y_q);
        sub   = 1'b1;
      end
      default: ;
    endcase
    sum = add_a + (add_b ^ {(W+2){sub}}) + (W+2)'(sub);
    ge  = ~sum[W+1];
  end

  always_comb begin
    x_n   = x_q;
    y_n   = y_q;
    acc_n = acc_q;
    case (op_q)
      ALU_MUL: begin
        acc_n = y_q[0] ? sum[W-1:0] : acc_q;
        x_n   = x_q << 1;
        y_n   = y_q >> 1;
      end
      ALU_DIV: begin
        acc_n = ge ? sum[W-1:0] : rem_t[W-1:0];
        x_n   = {x_q[W-2:0], ge};
      end
      ALU_SQRT: begin
        x_n   = ge ? sum[W-1:0] : x_q;
        acc_n = ge ? ((acc_q >> 1) | y_q) : (acc_q >> 1);
        y_n   = y_q >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == ALU_SQRT) ? CNT_W'(W / 2) : CNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      x_q   <= a_i;
      y_q   <= (req_i.op == ALU_SQRT) ? SQRT_BIT : b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      x_q   <= x_n;
      y_q   <= y_n;
      acc_q <= acc_n;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign res_o      = (op_q == ALU_DIV) ? x_q : acc_q;

endmodule

`default_nettype wire

// File: hdl/frame_sharpness_exposure_gate.sv
// Pixel path: a pixel request steps through accept, center read, neighbor read and accumulate.
// A new pixel is accepted only in IDLE, a limit set by the single read port of each line store.
// Frame end: last-row pass (LRD, RD1, RD2, ACC per column), then 10 ops on the shared serial unit
//   (multiply, divide and square root, W = 2*ceil(log2(MAXW*MAXH+1))+32).
// Reset: async active low clears counters, sums, sequencer and registers; line stores are
//   not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// frame_sharpness_exposure_gate
// Variance-of-Laplacian blur metric with brightness / contrast checks.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_sharpness_exposure_gate_assert.svh"

module frame_sharpness_exposure_gate #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  fse_pix_if.sink                            pix_i,
  fse_res_if.source                          res_o,
  input  logic                               cfg_we_i,
  input  logic [fse_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fse_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import fse_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int GS_W   = CNT_W + 8;
  localparam int GQ_W   = CNT_W + 16;
  localparam int LS_W   = CNT_W + 11;
  localparam int LQ_W   = CNT_W + 20;
  localparam int W      = 2 * CNT_W + 32;

  // One-hot sequencer. Pixel path: IDLE -> RD1 -> RD2 -> ACC.
  // Last-row pass: LRD -> RD1 -> RD2 -> ACC per column.
  // Then blur (BL_*), brightness (BR_DIV), contrast (CT_*) and OUT.
  typedef enum logic [15:0] {
    S_IDLE    = 16'b0000_0000_0000_0001,
    S_RD1     = 16'b0000_0000_0000_0010,
    S_RD2     = 16'b0000_0000_0000_0100,
    S_ACC     = 16'b0000_0000_0000_1000,
    S_LRD     = 16'b0000_0000_0001_0000,
    S_BL_NQ   = 16'b0000_0000_0010_0000,
    S_BL_SS   = 16'b0000_0000_0100_0000,
    S_BL_NN   = 16'b0000_0000_1000_0000,
    S_BL_DIV  = 16'b0000_0001_0000_0000,
    S_BR_DIV  = 16'b0000_0010_0000_0000,
    S_CT_NQ   = 16'b0000_0100_0000_0000,
    S_CT_SS   = 16'b0000_1000_0000_0000,
    S_CT_NN   = 16'b0001_0000_0000_0000,
    S_CT_DIV  = 16'b0010_0000_0000_0000,
    S_CT_SQRT = 16'b0100_0000_0000_0000,
    S_OUT     = 16'b1000_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // ---------------- configuration registers ----------------
  logic                  color_mode_q;
  logic [CFG_DIM_W-1:0]  width_q, height_q;
  logic [BLUR_W-1:0]     min_blur_q;
  logic [BRIGHT_W-1:0]   min_bright_q, max_bright_q;
  logic [CONTRAST_W-1:0] min_con_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= RST_COLOR_MODE;
      width_q      <= RST_FRAME_WIDTH;
      height_q     <= RST_FRAME_HEIGHT;
      min_blur_q   <= RST_MIN_BLUR_SCORE;
      min_bright_q <= RST_MIN_BRIGHTNESS;
      max_bright_q <= RST_MAX_BRIGHTNESS;
      min_con_q    <= RST_MIN_CONTRAST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR_MODE:     color_mode_q <= cfg_data_i[0];
        CFG_FRAME_WIDTH:    width_q      <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_FRAME_HEIGHT:   height_q     <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_MIN_BLUR_SCORE: min_blur_q   <= cfg_data_i[BLUR_W-1:0];
        CFG_MIN_BRIGHTNESS: min_bright_q <= cfg_data_i[BRIGHT_W-1:0];
        CFG_MAX_BRIGHTNESS: max_bright_q <= cfg_data_i[BRIGHT_W-1:0];
        CFG_MIN_CONTRAST:   min_con_q    <= cfg_data_i[CONTRAST_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to [2, MAX], kept as last index
  logic [CW-1:0] w_m1;
  logic [RW-1:0] h_m1;

  always_comb begin
    if (width_q < CFG_DIM_W'(2)) begin
      w_m1 = CW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(width_q - CFG_DIM_W'(1));
    end
    if (height_q < CFG_DIM_W'(2)) begin
      h_m1 = RW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RW'(height_q - CFG_DIM_W'(1));
    end
  end

  // ---------------- gray conversion ----------------
  logic [GRAY_MIX_W-1:0] gray_mix;
  logic [PIX_W-1:0]      gray_in;

  assign gray_mix = GRAY_MIX_W'(pix_i.blue_or_gray) * GRAY_MIX_W'(GRAY_B_COEF)
                  + GRAY_MIX_W'(pix_i.green)        * GRAY_MIX_W'(GRAY_G_COEF)
                  + GRAY_MIX_W'(pix_i.red)          * GRAY_MIX_W'(GRAY_R_COEF)
                  + GRAY_MIX_W'(GRAY_ROUND);
  assign gray_in  = color_mode_q ? gray_mix[GRAY_SHIFT +: PIX_W] : pix_i.blue_or_gray;

  // ---------------- line stores ----------------
  // newer holds the previous row (then the current one as it is written),
  // older the row above that.
  logic [CW-1:0]    c_q, last_c_q;
  logic [RW-1:0]    r_q;
  logic             sweep_q;
  logic [CW-1:0]    newer_raddr;
  logic [PIX_W-1:0] newer_rdata, older_rdata;
  logic             line_we;
  logic [PIX_W-1:0] g_q, mid_q, up_q, win_left_q;

  assign newer_raddr = (state_q == S_RD1) ? ((c_q == '0) ? CW'(1) : c_q + 1'b1) : c_q;
  assign line_we     = (state_q == S_RD2) && !sweep_q;

  fse_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_newer (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (c_q),
    .wdata_i (g_q),
    .raddr_i (newer_raddr),
    .rdata_o (newer_rdata)
  );

  fse_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_row_older (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (c_q),
    .wdata_i (mid_q),
    .raddr_i (c_q),
    .rdata_o (older_rdata)
  );

  // ---------------- Laplacian ----------------
  // Reflect-101: left of column 0 and right of the last column is column 1 /
  // the left neighbor. First row above reflects to the row below (gray),
  // and on the last-row pass the row below reflects to the row above.
  logic [PIX_W-1:0]  lap_left, lap_right, term_a, term_b;
  logic              right_edge;
  logic [11:0]       lap_sum12;
  logic signed [10:0] lap_q;
  logic signed [21:0] lap_sq_full;
  logic [15:0]       g_sq;

  always_comb begin
    lap_left   = (c_q == '0) ? newer_rdata : win_left_q;
    right_edge = sweep_q ? (c_q >= last_c_q) : (c_q >= w_m1);
    lap_right  = right_edge ? lap_left : newer_rdata;
    term_a     = (!sweep_q && (r_q == RW'(1))) ? g_q : up_q;
    term_b     = sweep_q ? up_q : g_q;
    lap_sum12  = 12'(term_a) + 12'(term_b) + 12'(lap_left) + 12'(lap_right)
               - {2'b00, mid_q, 2'b00};
  end

  assign lap_sq_full = lap_q * lap_q;
  assign g_sq        = g_q * g_q;

  // ---------------- accumulators ----------------
  logic [GS_W-1:0]        gs_q;
  logic [GQ_W-1:0]        gq_q;
  logic signed [LS_W-1:0] ls_q;
  logic [LQ_W-1:0]        lq_q;
  logic [CNT_W-1:0]       npix_q, nlap_q;
  logic [LS_W-1:0]        ls_abs;

  assign ls_abs = ls_q[LS_W-1] ? LS_W'(-ls_q) : LS_W'(ls_q);

  // ---------------- shared serial unit ----------------
  alu_req_t     alu_req;
  alu_rsp_t     alu_rsp;
  logic [W-1:0] alu_a, alu_b, alu_res;
  logic         issued_q, issued_d;
  logic         in_math;
  logic [W-1:0] p1_q, p2_q, nn_q, diff;

  assign diff = (p1_q >= p2_q) ? p1_q - p2_q : '0;

  assign in_math = (state_q == S_BL_NQ) || (state_q == S_BL_SS) || (state_q == S_BL_NN)
                || (state_q == S_BL_DIV) || (state_q == S_BR_DIV) || (state_q == S_CT_NQ)
                || (state_q == S_CT_SS) || (state_q == S_CT_NN) || (state_q == S_CT_DIV)
                || (state_q == S_CT_SQRT);

  fse_alu #(.W(W)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  // ---------------- sequencer ----------------
  logic out_valid_q;
  logic out_load;

  assign out_load = (state_q == S_OUT) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d     = state_q;
    alu_req.op  = ALU_MUL;
    alu_a       = '0;
    alu_b       = '0;
    unique case (state_q)
      S_IDLE: if (pix_i.valid) state_d = S_RD1;
      S_RD1:  state_d = S_RD2;
      S_RD2:  state_d = S_ACC;
      S_ACC: begin
        if (sweep_q) begin
          state_d = (c_q == last_c_q) ? S_BL_NQ : S_LRD;
        end else if ((c_q >= w_m1) && (r_q >= h_m1)) begin
          state_d = S_LRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LRD: state_d = S_RD1;
      // blur: N*Q, S*S, N*N, then rounded (N*Q - S*S) * 256 / N^2
      S_BL_NQ: begin
        alu_a = W'(nlap_q);
        alu_b = W'(lq_q);
        if (alu_rsp.done) state_d = S_BL_SS;
      end
      S_BL_SS: begin
        alu_a = W'(ls_abs);
        alu_b = W'(ls_abs);
        if (alu_rsp.done) state_d = S_BL_NN;
      end
      S_BL_NN: begin
        alu_a = W'(nlap_q);
        alu_b = W'(nlap_q);
        if (alu_rsp.done) state_d = S_BL_DIV;
      end
      S_BL_DIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = (diff << 8) + (nn_q >> 1);
        alu_b      = nn_q;
        if (alu_rsp.done) state_d = S_BR_DIV;
      end
      // brightness: rounded 256 * sum / N
      S_BR_DIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = (W'(gs_q) << 8) + W'(npix_q >> 1);
        alu_b      = W'(npix_q);
        if (alu_rsp.done) state_d = S_CT_NQ;
      end
      // contrast: isqrt(floor(65536 * variance))
      S_CT_NQ: begin
        alu_a = W'(npix_q);
        alu_b = W'(gq_q);
        if (alu_rsp.done) state_d = S_CT_SS;
      end
      S_CT_SS: begin
        alu_a = W'(gs_q);
        alu_b = W'(gs_q);
        if (alu_rsp.done) state_d = S_CT_NN;
      end
      S_CT_NN: begin
        alu_a = W'(npix_q);
        alu_b = W'(npix_q);
        if (alu_rsp.done) state_d = S_CT_DIV;
      end
      S_CT_DIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = diff << 16;
        alu_b      = nn_q;
        if (alu_rsp.done) state_d = S_CT_SQRT;
      end
      S_CT_SQRT: begin
        alu_req.op = ALU_SQRT;
        alu_a      = p1_q;
        if (alu_rsp.done) state_d = S_OUT;
      end
      S_OUT: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // one start per op state; cleared when the op completes
  always_comb begin
    alu_req.start = in_math && !issued_q;
    issued_d      = issued_q;
    if (alu_req.start) issued_d = 1'b1;
    if (alu_rsp.done)  issued_d = 1'b0;
  end

  // ---------------- result capture ----------------
  logic [BLUR_W-1:0]     blur_q;
  logic [BRIGHT_W-1:0]   bright_q;
  logic [CONTRAST_W-1:0] con_q;

  always_ff @(posedge clk_i) begin
    if (alu_rsp.done) begin
      unique case (state_q)
        S_BL_NQ, S_CT_NQ: p1_q <= alu_res;
        S_BL_SS, S_CT_SS: p2_q <= alu_res;
        S_BL_NN, S_CT_NN: nn_q <= alu_res;
        S_BL_DIV: blur_q <= (|alu_res[W-1:BLUR_W]) ? '1 : alu_res[BLUR_W-1:0];
        S_BR_DIV: bright_q <= (|alu_res[W-1:BRIGHT_W]) ? '1 : alu_res[BRIGHT_W-1:0];
        S_CT_DIV: p1_q <= alu_res;
        S_CT_SQRT: con_q <= (|alu_res[W-1:CONTRAST_W]) ? '1 : alu_res[CONTRAST_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pixel path payload ----------------
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && pix_i.valid) begin
      g_q <= gray_in;
    end
    if (state_q == S_RD1) begin
      mid_q <= newer_rdata;
      up_q  <= older_rdata;
    end
    if (state_q == S_RD2) begin
      lap_q <= lap_sum12[10:0];
    end
  end

  // ---------------- control, counters and sums ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      issued_q   <= 1'b0;
      c_q        <= '0;
      r_q        <= '0;
      last_c_q   <= '0;
      sweep_q    <= 1'b0;
      win_left_q <= '0;
      gs_q       <= '0;
      gq_q       <= '0;
      ls_q       <= '0;
      lq_q       <= '0;
      npix_q     <= '0;
      nlap_q     <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (state_q == S_ACC) begin
        win_left_q <= mid_q;
        if (sweep_q || (r_q != '0)) begin
          ls_q   <= ls_q + LS_W'(lap_q);
          lq_q   <= lq_q + LQ_W'(lap_sq_full[19:0]);
          nlap_q <= nlap_q + 1'b1;
        end
        if (sweep_q) begin
          if (c_q == last_c_q) begin
            c_q     <= '0;
            sweep_q <= 1'b0;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end else begin
          gs_q   <= gs_q + GS_W'(g_q);
          gq_q   <= gq_q + GQ_W'(g_sq);
          npix_q <= npix_q + 1'b1;
          if (c_q >= w_m1) begin
            c_q <= '0;
            if (r_q >= h_m1) begin
              // last pixel: start the last-row pass
              r_q      <= '0;
              last_c_q <= c_q;
              sweep_q  <= 1'b1;
            end else begin
              r_q <= r_q + 1'b1;
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
      end
      if (out_load) begin
        win_left_q <= '0;
        gs_q       <= '0;
        gq_q       <= '0;
        ls_q       <= '0;
        lq_q       <= '0;
        npix_q     <= '0;
        nlap_q     <= '0;
      end
    end
  end

  // ---------------- output register ----------------
  logic                  flag_blur, flag_dark, flag_bright, flag_low;
  logic [BLUR_W-1:0]     out_blur_q;
  logic [BRIGHT_W-1:0]   out_bright_q;
  logic [CONTRAST_W-1:0] out_con_q;
  logic                  out_blurry_q, out_dark_q, out_brightf_q, out_low_q;

  assign flag_blur   = blur_q < min_blur_q;
  assign flag_dark   = bright_q < min_bright_q;
  assign flag_bright = !flag_dark && (bright_q > max_bright_q);  // only if not dark
  assign flag_low    = con_q < min_con_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_blur_q    <= blur_q;
      out_bright_q  <= bright_q;
      out_con_q     <= con_q;
      out_blurry_q  <= flag_blur;
      out_dark_q    <= flag_dark;
      out_brightf_q <= flag_bright;
      out_low_q     <= flag_low;
    end
  end

  assign pix_i.ready        = (state_q == S_IDLE);
  assign res_o.valid        = out_valid_q;
  assign res_o.blur_score   = out_blur_q;
  assign res_o.brightness   = out_bright_q;
  assign res_o.contrast     = out_con_q;
  assign res_o.too_blurry   = out_blurry_q;
  assign res_o.too_dark     = out_dark_q;
  assign res_o.too_bright   = out_brightf_q;
  assign res_o.low_contrast = out_low_q;
  assign res_o.usable       = !(out_blurry_q || out_dark_q || out_brightf_q || out_low_q);

  // ---------------- assertions ----------------
  `FSEG_ASSERT_NXT(a_accept_reads, clk_i, rst_ni, pix_i.valid && pix_i.ready, state_q == S_RD1, "pixel request did not start the line-store read")
  `FSEG_ASSERT_NOW(a_alu_done_math, clk_i, rst_ni, alu_rsp.done, in_math && issued_q, "serial unit finished outside a math step")
  `FSEG_ASSERT_NOW(a_result_clears, clk_i, rst_ni, $rose(out_valid_q), (c_q == '0) && (r_q == '0) && (npix_q == '0) && !sweep_q, "frame state not cleared with result")

endmodule

`default_nettype wire
